// ===== rtl/tht_pkg.sv =====
package tht_pkg;

  localparam int KEY_W     = 32;
  localparam int HANDLE_W  = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD            = 3'd0,
    CMD_LOOKUP         = 3'd1,
    CMD_INVALIDATE     = 3'd2,
    CMD_INVALIDATE_ALL = 3'd3,
    CMD_CLEAR          = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic pick;
    logic exec;
    logic load;
  } ctrl_t;

endpackage

// ===== rtl/tagged_handle_table.sv =====
// tagged_handle_table: associative key to handle table with per-slot valid bits
//
// input channel (in_valid / in_stall): one command with key and handle per
// transfer; commands are add, lookup, invalidate key, invalidate all, clear.
// result channel (out_valid / out_stall): exactly one result per command with
// status, hit, handle and the valid and used slot counts after the command.
// cfg_wr_en / cfg_wr_data write cache_enable (reset 1); write only when idle.
//
// a new command is taken only after the previous one has gone through the
// parallel key compare, first-match select, table update and the registered
// read of the handle ram; the input is stalled meanwhile.
// the next command is taken while a result waits in the output register; if
// the receiver keeps stalling, the block holds the finished command and
// stalls the input until the output register is free.
// reset (synchronous, rst_n low) empties the table, clears all valid bits,
// drops any pending result and sets cache_enable to 1. no clearing pass.
module tagged_handle_table
  import tht_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [HANDLE_W-1:0]  in_handle_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_hit,
  output logic [HANDLE_W-1:0]  out_handle_out,
  output logic [OUT_CNT_W-1:0] out_valid_count,
  output logic [OUT_CNT_W-1:0] out_used_count
);

  ctrl_t ctl;

  tht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  tht_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_handle_in    (in_handle_in),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_handle_out  (out_handle_out),
    .out_valid_count (out_valid_count),
    .out_used_count  (out_used_count)
  );

endmodule

// ===== rtl/tht_ram.sv =====
module tht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tht_ctrl.sv =====
module tht_ctrl
  import tht_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output ctrl_t ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_PICK;
        end
      end
      S_PICK: begin
        ctl.pick  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          ctl.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/tht_datapath.sv =====
module tht_datapath
  import tht_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctl,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [HANDLE_W-1:0]  in_handle_in,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_hit,
  output logic [HANDLE_W-1:0]  out_handle_out,
  output logic [OUT_CNT_W-1:0] out_valid_count,
  output logic [OUT_CNT_W-1:0] out_used_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic                 enable_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [HANDLE_W-1:0]  hin_r;
  logic [SLOTS-1:0]     match_r;
  logic [SLOTS-1:0]     first_r;
  logic                 found_r;
  logic [KEY_W-1:0]     slot_key_r [SLOTS];
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        vcnt_r, vcnt_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic [STATUS_W-1:0]  o_status_r;
  logic                 o_hit_r;
  logic [HANDLE_W-1:0]  o_handle_r;
  logic [OUT_CNT_W-1:0] o_vcnt_r, o_fill_r;

  logic [SLOTS-1:0]     match_c;
  logic                 need_valid;
  logic [IW-1:0]        sel_idx;
  logic                 sel_valid;
  logic                 key_we;
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [HANDLE_W-1:0]  ram_rdata;

  assign need_valid = (in_command == CMD_LOOKUP);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_c[i] = (slot_key_r[i] == in_key) && (CW'(i) < fill_r) &&
                   (!need_valid || valid_r[i]);
    end
  end

  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first_r[i]) begin
        sel_idx = sel_idx | IW'(i);
      end
    end
  end

  assign sel_valid = |(first_r & valid_r);

  always_comb begin
    valid_nxt      = valid_r;
    fill_nxt       = fill_r;
    vcnt_nxt       = vcnt_r;
    res_status_nxt = ST_OK;
    res_hit_nxt    = 1'b0;
    key_we         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = found_r ? sel_idx : fill_r[IW-1:0];
    if (ctl.exec) begin
      unique case (cmd_r)
        CMD_ADD: begin
          if (!enable_r) begin
            res_status_nxt = ST_DISABLED;
          end else if (fill_r == CW'(SLOTS)) begin
            res_status_nxt = ST_FULL;
          end else if (found_r) begin
            ram_we    = 1'b1;
            valid_nxt = valid_r | first_r;
            if (!sel_valid) begin
              vcnt_nxt = vcnt_r + CW'(1);
            end
          end else begin
            ram_we                      = 1'b1;
            key_we                      = 1'b1;
            valid_nxt[fill_r[IW-1:0]]   = 1'b1;
            fill_nxt                    = fill_r + CW'(1);
            vcnt_nxt                    = vcnt_r + CW'(1);
          end
        end
        CMD_LOOKUP: begin
          res_hit_nxt = enable_r && found_r;
        end
        CMD_INVALIDATE: begin
          if (found_r && sel_valid) begin
            valid_nxt = valid_r & ~first_r;
            vcnt_nxt  = vcnt_r - CW'(1);
          end
        end
        CMD_INVALIDATE_ALL: begin
          valid_nxt = '0;
          vcnt_nxt  = '0;
        end
        CMD_CLEAR: begin
          valid_nxt = '0;
          vcnt_nxt  = '0;
          fill_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      valid_r  <= '0;
      fill_r   <= '0;
      vcnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= in_command;
      key_r   <= in_key;
      hin_r   <= in_handle_in;
      match_r <= match_c;
    end
    if (ctl.pick) begin
      first_r <= match_r & (~match_r + SLOTS'(1));
      found_r <= |match_r;
    end
    if (ctl.exec) begin
      res_status_r <= res_status_nxt;
      res_hit_r    <= res_hit_nxt;
    end
    if (ctl.load) begin
      o_status_r <= res_status_r;
      o_hit_r    <= res_hit_r;
      o_handle_r <= res_hit_r ? ram_rdata : '0;
      o_vcnt_r   <= OUT_CNT_W'(vcnt_r);
      o_fill_r   <= OUT_CNT_W'(fill_r);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (key_we && fill_r == CW'(i)) begin
        slot_key_r[i] <= key_r;
      end
    end
  end

  tht_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (SLOTS)
  ) u_handle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (hin_r),
    .raddr (sel_idx),
    .rdata (ram_rdata)
  );

  assign out_status      = o_status_r;
  assign out_hit         = o_hit_r;
  assign out_handle_out  = o_handle_r;
  assign out_valid_count = o_vcnt_r;
  assign out_used_count  = o_fill_r;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tht_pkg::*;

  localparam int SLOTS        = 32;
  localparam int POOL_SIZE    = 40;
  localparam int NUM_SEGS     = 6;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int STUCK_LIMIT  = 2000;
  localparam bit [NUM_SEGS-1:0] SEG_ENABLE = 6'b100101;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_CLEAR + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

  typedef struct {
    bit                  pause;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } cmd_item_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic                 hit;
    logic [HANDLE_W-1:0]  handle;
    logic [OUT_CNT_W-1:0] valid_cnt;
    logic [OUT_CNT_W-1:0] used_cnt;
  } table_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command = '0;
  logic [KEY_W-1:0]     in_key = '0;
  logic [HANDLE_W-1:0]  in_handle_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_hit;
  logic [HANDLE_W-1:0]  out_handle_out;
  logic [OUT_CNT_W-1:0] out_valid_count;
  logic [OUT_CNT_W-1:0] out_used_count;

  tagged_handle_table #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_key(in_key),
    .in_handle_in(in_handle_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_hit(out_hit),
    .out_handle_out(out_handle_out),
    .out_valid_count(out_valid_count),
    .out_used_count(out_used_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mirror of the table contents
  logic [KEY_W-1:0]    mirror_key[SLOTS];
  logic [HANDLE_W-1:0] mirror_handle[SLOTS];
  bit                  mirror_valid[SLOTS];
  int                  mirror_fill = 0;
  bit                  mirror_enable = 1'b1;

  cmd_item_t     cmd_q[$];
  table_result_t awaited_replies[$];
  table_result_t reply_want;
  cmd_item_t     nxt;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int n_offered = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_hits = 0;
  int n_full = 0;
  int n_disabled = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stuck = 0;

  function automatic int find_slot(logic [KEY_W-1:0] k, bit need_valid);
    for (int i = 0; i < mirror_fill; i++) begin
      if (mirror_key[i] == k && (!need_valid || mirror_valid[i])) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic table_result_t table_apply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                                logic [HANDLE_W-1:0] h);
    table_result_t r;
    int idx;
    int n;
    r.status = ST_OK;
    r.hit    = 1'b0;
    r.handle = '0;
    case (cmd)
      CMD_ADD: begin
        if (!mirror_enable) begin
          r.status = ST_DISABLED;
          n_disabled++;
        end else if (mirror_fill >= SLOTS) begin
          // full check wins even when the key is already present
          r.status = ST_FULL;
          n_full++;
        end else begin
          idx = find_slot(key, 1'b0);
          if (idx < 0) begin
            idx = mirror_fill;
            mirror_fill++;
            mirror_key[idx] = key;
          end
          mirror_handle[idx] = h;
          mirror_valid[idx]  = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (mirror_enable) begin
          idx = find_slot(key, 1'b1);
          if (idx >= 0) begin
            r.hit    = 1'b1;
            r.handle = mirror_handle[idx];
            n_hits++;
          end
        end
      end
      CMD_INVALIDATE: begin
        idx = find_slot(key, 1'b0);
        if (idx >= 0) begin
          mirror_valid[idx] = 1'b0;
        end
      end
      CMD_INVALIDATE_ALL: begin
        foreach (mirror_valid[i]) mirror_valid[i] = 1'b0;
      end
      CMD_CLEAR: begin
        foreach (mirror_valid[i]) begin
          mirror_valid[i]  = 1'b0;
          mirror_key[i]    = '0;
          mirror_handle[i] = '0;
        end
        mirror_fill = 0;
      end
      default: begin
      end
    endcase
    n = 0;
    for (int i = 0; i < mirror_fill; i++) begin
      if (mirror_valid[i]) n++;
    end
    r.valid_cnt = OUT_CNT_W'(n);
    r.used_cnt  = OUT_CNT_W'(mirror_fill);
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // prediction on input transfers, checking on result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(table_apply(in_command, in_key, in_handle_in));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d hit %0d handle %0h",
                   $time, out_status, out_hit, out_handle_out);
          n_errors++;
        end else begin
          reply_want = awaited_replies.pop_front();
          n_errors += !field_ok("status", reply_want.status, out_status);
          n_errors += !field_ok("hit", reply_want.hit, out_hit);
          n_errors += !field_ok("handle_out", reply_want.handle, out_handle_out);
          n_errors += !field_ok("valid_count", reply_want.valid_cnt, out_valid_count);
          n_errors += !field_ok("used_count", reply_want.used_cnt, out_used_count);
        end
      end
      if (cfg_wr_en) begin
        mirror_enable = cfg_wr_data;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck);
      $display("FAIL");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (n_offered == n_accepted) begin
      if (cmd_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (cmd_q[0].pause) begin
        // drain: hold off until every result is back
        in_valid <= 1'b0;
        if (awaited_replies.size() == 0) begin
          cmd_q.delete(0);
        end
      end else if ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        in_command   <= nxt.cmd;
        in_key       <= nxt.key;
        in_handle_in <= nxt.handle;
        in_valid     <= 1'b1;
        n_offered++;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    cmd_item_t it;
    it.pause  = 1'b0;
    it.cmd    = c;
    it.key    = k;
    it.handle = h;
    cmd_q.push_back(it);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) == 0) begin
      return $urandom;
    end
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic gen_traffic(int count, bit with_pause);
    int made;
    int roll;
    int burst;
    bit paused;
    logic [KEY_W-1:0] first_key;
    cmd_item_t marker;
    made   = 0;
    paused = 1'b0;
    marker.pause  = 1'b1;
    marker.cmd    = CMD_LOOKUP;
    marker.key    = '0;
    marker.handle = '0;
    while (made < count) begin
      if (with_pause && !paused && made >= count / 2) begin
        cmd_q.push_back(marker);
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
        // fill burst of fresh keys, then re-add and look up the first key
        burst = $urandom_range(36, 20);
        first_key = $urandom;
        push_cmd(CMD_ADD, first_key, $urandom);
        for (int i = 1; i < burst; i++) push_cmd(CMD_ADD, $urandom, $urandom);
        push_cmd(CMD_ADD, first_key, $urandom);
        push_cmd(CMD_LOOKUP, first_key, $urandom);
        made += burst + 2;
      end else begin
        if (roll < 6) begin
          push_cmd(CMD_CLEAR, $urandom, $urandom);
        end else if (roll < 9) begin
          push_cmd(CMD_INVALIDATE_ALL, pick_key(), $urandom);
        end else if (roll < 12) begin
          push_cmd(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), pick_key(), $urandom);
        end else if (roll < 46) begin
          push_cmd(CMD_ADD, pick_key(), $urandom);
        end else if (roll < 80) begin
          push_cmd(CMD_LOOKUP, pick_key(), $urandom);
        end else begin
          push_cmd(CMD_INVALIDATE, pick_key(), $urandom);
        end
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || n_offered != n_accepted || awaited_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int seg;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      wait_idle();
      case (seg / 2)
        0: begin
          send_gap_pct   = 9;
          recv_stall_pct = 68;
        end
        1: begin
          send_gap_pct   = 68;
          recv_stall_pct = 9;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= SEG_ENABLE[seg];
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
      @(posedge clk);

      if (seg == 0) begin
        push_cmd(CMD_ADD, '0, '0);
        push_cmd(CMD_ADD, '1, '1);
        push_cmd(CMD_LOOKUP, '0, $urandom);
        push_cmd(CMD_LOOKUP, '1, $urandom);
        push_cmd(CMD_LOOKUP, 32'ha5a5_5a5a, $urandom);
        push_cmd(CMD_ADD, '0, 32'h1234_5678);
        push_cmd(CMD_LOOKUP, '0, '0);
        push_cmd(CMD_INVALIDATE, '0, '1);
        push_cmd(CMD_LOOKUP, '0, '0);
        push_cmd(CMD_INVALIDATE, '0, '0);
        push_cmd(CMD_ADD, '0, 32'h8000_0001);
        push_cmd(CMD_LOOKUP, '0, '0);
        push_cmd(CMD_INVALIDATE, 32'h0bad_f00d, '0);
        push_cmd(CMD_INVALIDATE_ALL, '0, '0);
        push_cmd(CMD_LOOKUP, '1, '0);
        push_cmd(CMD_ADD, '1, 32'h7fff_fffe);
        push_cmd(CMD_LOOKUP, '1, '0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
          push_cmd(CMD_W'(c), '1, '1);
        end
        push_cmd(CMD_CLEAR, '1, '1);
        push_cmd(CMD_LOOKUP, '1, '0);
        push_cmd(CMD_LOOKUP, '0, '0);
      end
      gen_traffic(SEG_ENABLE[seg] ? 340 : 120, seg == 0 || seg == 2);
    end

    wait_idle();
    $display("covered %0d commands over %0d cache_enable phases, with a long result hold",
             n_accepted, NUM_SEGS);
    $display("lookup hits %0d, adds refused full %0d, adds refused disabled %0d",
             n_hits, n_full, n_disabled);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
